// ===== src/bpa_pkg.sv =====
// Shared constants and types for the bitmap page allocator.
package bpa_pkg;

  localparam int NumPages  = 4096;
  localparam int WordBits  = 64;
  localparam int NumWords  = NumPages / WordBits;
  localparam int PageW     = 12;
  localparam int LenW      = 13;
  localparam int WordIdxW  = 6;
  localparam int BitIdxW   = 6;
  localparam int CountMax  = 8191;
  localparam int QDepth    = 2;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  // One classified request between front and back.
  typedef struct packed {
    logic             is_free;
    logic             skip;      // free at page 0: no effect, ok = 0
    logic [LenW-1:0]  len;
    logic [PageW-1:0] start;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [PageW-1:0] first_page;
    logic [LenW-1:0]  pages_in_use;
  } rsp_t;

endpackage

// ===== src/bpa_front.sv =====
// Front part: accepts input transfers, classifies them and queues them.
module bpa_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [12:0]        run_length,
  input  logic [11:0]        free_page,
  output logic               q_valid,
  input  logic               q_pop,
  output bpa_pkg::req_t      q_head
);

  bpa_pkg::req_t q_mem_r [bpa_pkg::QDepth];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  bpa_pkg::req_t req_in;
  logic          push;

  always_comb begin
    req_in.is_free = (func == bpa_pkg::FuncFree);
    req_in.skip    = (func == bpa_pkg::FuncFree) && (free_page == '0);
    req_in.len     = run_length;
    req_in.start   = free_page;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_head   = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("queue count not advanced");

endmodule

// ===== src/bpa_back.sv =====
// Back part: word-serial first-fit scan, mark and clear passes over the bitmap.
module bpa_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  bpa_pkg::req_t      q_head,
  output logic               out_valid,
  input  logic               out_ready,
  output bpa_pkg::rsp_t      out_rsp
);

  localparam logic [2:0] StInit  = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StScan  = 3'd2;
  localparam logic [2:0] StRd    = 3'd3;
  localparam logic [2:0] StWr    = 3'd4;
  localparam logic [2:0] StResp  = 3'd5;

  logic [bpa_pkg::WordBits-1:0] mem_r [bpa_pkg::NumWords];
  logic [bpa_pkg::WordBits-1:0] rd_r;

  logic [2:0]                   st_r;
  logic [bpa_pkg::WordIdxW:0]   w_r;       // word index, extra bit for end
  logic [bpa_pkg::LenW-1:0]     run_r;
  logic [bpa_pkg::PageW-1:0]    first_r;
  logic                         found_r;
  bpa_pkg::req_t                req_r;
  logic [bpa_pkg::PageW:0]      pos_r;     // next page to mark or clear
  logic [bpa_pkg::LenW:0]       left_r;
  logic [bpa_pkg::LenW-1:0]     cnt_r;
  logic                         ovalid_r;
  bpa_pkg::rsp_t                orsp_r;
  bpa_pkg::rsp_t                res_r;     // result waiting for the output register

  // Run length ending at each bit of the word in rd_r, all bits side by side.
  logic [bpa_pkg::WordIdxW:0]   sc_word;
  logic [bpa_pkg::WordBits-1:0] sc_hitv;
  logic [bpa_pkg::LenW-1:0]     sc_run;
  logic                         sc_hit;
  logic [bpa_pkg::BitIdxW-1:0]  sc_bit;
  logic [bpa_pkg::PageW:0]      sc_page;
  logic [bpa_pkg::PageW-1:0]    sc_first;
  logic                         lu_hit;
  logic [bpa_pkg::BitIdxW-1:0]  lu_pos;
  logic [bpa_pkg::LenW-1:0]     run_end;

  // rd_r holds the word fetched in the previous cycle
  assign sc_word = w_r - 1'b1;

  always_comb begin
    sc_hitv = '0;
    lu_hit  = 1'b0;
    lu_pos  = '0;
    run_end = '0;
    for (int b = 0; b < bpa_pkg::WordBits; b++) begin
      lu_hit = 1'b0;
      lu_pos = '0;
      // last used bit at or below b
      for (int j = 0; j <= b; j++) begin
        if (rd_r[j]) begin
          lu_hit = 1'b1;
          lu_pos = j[bpa_pkg::BitIdxW-1:0];
        end
      end
      if (lu_hit) begin
        run_end = bpa_pkg::LenW'(b[bpa_pkg::BitIdxW-1:0]) - bpa_pkg::LenW'(lu_pos);
      end else begin
        run_end = run_r + bpa_pkg::LenW'(b[bpa_pkg::BitIdxW-1:0]) + 1'b1;
      end
      sc_hitv[b] = !rd_r[b] && (run_end >= req_r.len);
    end
    // carry the run ending at the top bit into the next word
    sc_run = run_end;
    sc_bit = '0;
    for (int b = bpa_pkg::WordBits - 1; b >= 0; b--) begin
      if (sc_hitv[b]) sc_bit = b[bpa_pkg::BitIdxW-1:0];
    end
    sc_hit   = |sc_hitv;
    sc_page  = {1'b0, sc_word[bpa_pkg::WordIdxW-1:0], sc_bit};
    sc_first = (req_r.len == '0) ? sc_page[bpa_pkg::PageW-1:0] :
               bpa_pkg::PageW'(sc_page + 1'b1 - req_r.len);
  end

  // Mask of bits in the current word covered by [pos_r, pos_r+left_r).
  logic [bpa_pkg::WordBits-1:0] wmask;
  logic [bpa_pkg::BitIdxW:0]    lo;
  logic [bpa_pkg::LenW+1:0]     hi;
  logic [bpa_pkg::BitIdxW:0]    span;

  always_comb begin
    lo = {1'b0, pos_r[bpa_pkg::BitIdxW-1:0]};
    hi = {1'b0, lo} + {1'b0, left_r};
    if (hi > (bpa_pkg::LenW+2)'(bpa_pkg::WordBits)) begin
      span = 7'(bpa_pkg::WordBits) - lo;
    end else begin
      span = 7'(hi) - lo;
    end
    for (int b = 0; b < bpa_pkg::WordBits; b++) begin
      wmask[b] = (7'(b) >= lo) && (7'(b) < lo + span);
    end
  end

  logic [bpa_pkg::LenW:0] cnt_sum;
  assign cnt_sum = {1'b0, cnt_r} + {1'b0, req_r.len};

  assign q_pop     = (st_r == StIdle) && q_valid;
  assign out_valid = ovalid_r;
  assign out_rsp   = orsp_r;

  logic [bpa_pkg::WordIdxW-1:0] widx;
  assign widx = (st_r == StScan || st_r == StInit) ? w_r[bpa_pkg::WordIdxW-1:0]
                : pos_r[bpa_pkg::PageW-1:bpa_pkg::BitIdxW];

  always_ff @(posedge clk) begin
    rd_r <= mem_r[widx];
    if (st_r == StInit) begin
      mem_r[w_r[bpa_pkg::WordIdxW-1:0]] <= '1;
    end else if (st_r == StWr) begin
      mem_r[pos_r[bpa_pkg::PageW-1:bpa_pkg::BitIdxW]] <=
        req_r.is_free ? (rd_r & ~wmask) : (rd_r | wmask);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= StInit;
      w_r      <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
      run_r    <= '0;
      found_r  <= 1'b0;
    end else begin
      if (st_r == StResp && (!ovalid_r || out_ready)) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
      case (st_r)
        StInit: begin
          w_r <= w_r + 1'b1;
          if (w_r == 7'(bpa_pkg::NumWords - 1)) st_r <= StIdle;
        end
        StIdle: begin
          if (q_valid) begin
            req_r   <= q_head;
            run_r   <= '0;
            found_r <= 1'b0;
            w_r     <= '0;
            pos_r   <= {1'b0, q_head.start};
            left_r  <= {1'b0, q_head.len};
            if (q_head.skip) begin
              res_r <= '{ok: 1'b0, first_page: '0, pages_in_use: cnt_r};
              st_r  <= StResp;
            end else if (q_head.is_free) begin
              st_r <= StRd;
            end else begin
              st_r <= StScan;
            end
          end
        end
        StScan: begin
          // rd_r holds word w_r-1 once the first fetch is done; use a phase via found_r
          if (!found_r) begin
            found_r <= 1'b1;       // the first scan step only fetches
          end else if (sc_hit) begin
            first_r <= sc_first;
            pos_r   <= {1'b0, sc_first};
            if (req_r.len == '0) begin
              res_r <= '{ok: 1'b1, first_page: sc_first, pages_in_use: cnt_r};
              st_r  <= StResp;
            end else begin
              st_r <= StRd;
            end
          end else begin
            run_r <= sc_run;
            if (w_r == 7'(bpa_pkg::NumWords)) begin
              res_r <= '{ok: 1'b0, first_page: '0, pages_in_use: cnt_r};
              st_r  <= StResp;
            end
          end
          if (!found_r || !sc_hit) w_r <= w_r + 1'b1;
        end
        StRd: begin
          if (left_r == '0 || pos_r[bpa_pkg::PageW]) begin
            if (req_r.is_free) begin
              cnt_r <= (cnt_r > req_r.len) ? cnt_r - req_r.len : '0;
              res_r <= '{ok: 1'b1, first_page: '0,
                         pages_in_use: (cnt_r > req_r.len) ? cnt_r - req_r.len : '0};
            end else begin
              cnt_r <= (cnt_sum > 14'(bpa_pkg::CountMax)) ? 13'(bpa_pkg::CountMax)
                       : cnt_sum[bpa_pkg::LenW-1:0];
              res_r <= '{ok: 1'b1, first_page: first_r,
                         pages_in_use: (cnt_sum > 14'(bpa_pkg::CountMax)) ?
                         13'(bpa_pkg::CountMax) : cnt_sum[bpa_pkg::LenW-1:0]};
            end
            st_r <= StResp;
          end else begin
            st_r <= StWr;
          end
        end
        StWr: begin
          pos_r  <= pos_r + 13'(span);
          left_r <= left_r - 14'(span);
          st_r   <= StRd;
        end
        StResp: begin
          // hold until the output register is free
          if (!ovalid_r || out_ready) begin
            orsp_r <= res_r;
            st_r   <= StIdle;
          end
        end
        default: st_r <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == StResp && (!ovalid_r || out_ready)) |=> out_valid)
    else $error("response not presented");
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> st_r != StIdle)
    else $error("request dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_rsp))
    else $error("result changed while held");

endmodule

// ===== src/bitmap_page_allocator_unit.sv =====
// Top level of the bitmap page allocator.
//  channel | dir | tdata (low bit first)                        | tuser
//  in_     | in  | run_length[12:0], free_page[24:13], pad      | func
//  out_    | out | ok[0], first_page[12:1], pages_in_use[25:13] | -
// After reset an initial pass sets every page used; two inputs may queue meanwhile.
// Allocate: scans 64-page words first-fit (up to 64 words), then marks the run word by word.
// Free: clears the run with a read and a write per word; a free at page 0 changes nothing.
// Two requests queue in front; the back part holds while a result waits on out_tready.
module bitmap_page_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // run_length, free_page, zero pad
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // ok, first_page, pages_in_use, zero pad
);

  logic          q_valid, q_pop;
  bpa_pkg::req_t q_head;
  bpa_pkg::rsp_t rsp;

  bpa_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .func(in_tuser), .run_length(in_tdata[12:0]), .free_page(in_tdata[24:13]),
    .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
  );

  bpa_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_rsp(rsp)
  );

  assign out_tdata = {6'd0, rsp.pages_in_use, rsp.first_page, rsp.ok};

endmodule

// ===== test/tb.sv =====
// Testbench for the bitmap page allocator: first-fit model, scoreboard and random traffic.
module tb;

  class alloc_scoreboard;
    bit            used_map[bpa_pkg::NumPages];
    int unsigned   in_use;
    bpa_pkg::rsp_t pending[$];
    int            errors;

    function new();
      for (int i = 0; i < bpa_pkg::NumPages; i++) used_map[i] = 1'b1;
      in_use = 0;
      errors = 0;
    endfunction

    // Predict the response for an accepted request.
    function void note_request(logic func, logic [bpa_pkg::LenW-1:0] len,
                               logic [bpa_pkg::PageW-1:0] start);
      bpa_pkg::rsp_t r;
      int unsigned run;
      int first;
      bit found;
      r = '0;
      run = 0;
      found = 0;
      first = 0;
      if (func == bpa_pkg::FuncAlloc) begin
        for (int p = 0; p < bpa_pkg::NumPages; p++) begin
          if (used_map[p]) begin
            run = 0;
          end else begin
            run++;
            if (run >= len) begin
              found = 1;
              first = (len == 0) ? p : p + 1 - len;
              break;
            end
          end
        end
        if (found) begin
          for (int i = 0; i < len; i++) used_map[first + i] = 1'b1;
          in_use = in_use + len;
          if (in_use > bpa_pkg::CountMax) in_use = bpa_pkg::CountMax;
          r.ok = 1'b1;
          r.first_page = first[bpa_pkg::PageW-1:0];
        end
      end else if (start != 0) begin
        for (int i = 0; i < len; i++) begin
          if (start + i >= bpa_pkg::NumPages) break;
          used_map[start + i] = 1'b0;
        end
        in_use = (in_use > len) ? in_use - len : 0;
        r.ok = 1'b1;
      end
      r.pages_in_use = in_use[bpa_pkg::LenW-1:0];
      pending.push_back(r);
    endfunction

    function void check_response(logic [31:0] data);
      bpa_pkg::rsp_t got, want;
      got.ok = data[0];
      got.first_page = data[12:1];
      got.pages_in_use = data[25:13];
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response %h", data);
        return;
      end
      want = pending.pop_front();
      if (got !== want || data[31:26] !== '0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp ok=%0d first=%0d used=%0d, got ok=%0d first=%0d used=%0d",
                   want.ok, want.first_page, want.pages_in_use,
                   got.ok, got.first_page, got.pages_in_use);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;

  alloc_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_off = 0;
  int unsigned cycles = 0;

  bitmap_page_allocator_unit u_top (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Sink: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_response(out_tdata);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send(logic func, int len, int start);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {7'b0, start[bpa_pkg::PageW-1:0], len[bpa_pkg::LenW-1:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(func, len[bpa_pkg::LenW-1:0], start[bpa_pkg::PageW-1:0]);
  endtask

  task automatic random_item();
    int k;
    int n;
    k = $urandom_range(99);
    n = ($urandom_range(9) == 0) ? $urandom_range(4096) : $urandom_range(40);
    if (k < 45) send(bpa_pkg::FuncAlloc, n, 0);
    else if (k < 90) send(bpa_pkg::FuncFree, $urandom_range(60), $urandom_range(4095));
    else if (k < 95) send(bpa_pkg::FuncFree, $urandom_range(8191), $urandom_range(4095));
    else send($urandom_range(1), $urandom_range(8191), $urandom_range(4095));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: extremes and special cases.
    send(bpa_pkg::FuncAlloc, 0, 0);        // nothing free
    send(bpa_pkg::FuncAlloc, 1, 0);
    send(bpa_pkg::FuncFree, 5, 0);         // free at page 0 ignored
    send(bpa_pkg::FuncFree, 100, 4095);    // clamped at end
    send(bpa_pkg::FuncAlloc, 0, 4095);
    send(bpa_pkg::FuncAlloc, 1, 0);
    send(bpa_pkg::FuncFree, 8191, 1);      // free all but page 0
    send(bpa_pkg::FuncAlloc, 4095, 0);
    send(bpa_pkg::FuncAlloc, 4096, 0);
    send(bpa_pkg::FuncAlloc, 8191, 0);
    send(bpa_pkg::FuncFree, 4096, 1);
    send(bpa_pkg::FuncFree, 3, 2);         // already free
    send(bpa_pkg::FuncAlloc, 4095, 0);
    send(bpa_pkg::FuncAlloc, 4095, 0);
    send(bpa_pkg::FuncAlloc, 4095, 0);     // fails, nothing free
    send(bpa_pkg::FuncFree, 0, 2730);
    send(bpa_pkg::FuncFree, 2000, 1365);
    send(bpa_pkg::FuncAlloc, 64, 0);
    send(bpa_pkg::FuncAlloc, 0, 0);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 32 : 69) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 32 : 69) : 0;
      if (ph == 0) hold_off = 400;
      for (int i = 0; i < 320; i++) random_item();
    end
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
